[rtl/byte_pair_frequency_max_top_macros.svh]
// Assertion macros shared by the checker.
// All of them sample on the rising edge of clock and are held off during reset.
`ifndef BYTE_PAIR_FREQUENCY_MAX_TOP_MACROS_SVH
`define BYTE_PAIR_FREQUENCY_MAX_TOP_MACROS_SVH

// Same-cycle implication
`define BPFM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BPFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bpfm_pkg.sv]
package bpfm_pkg;

   // Fixed field widths
   localparam int BYTE_BITS      = 8;
   localparam int PAIR_BITS      = 16;
   localparam int TOP_COUNT_BITS = 16;
   localparam int DISTINCT_BITS  = 9;

   // Whitespace codes
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_CR      = 8'h0D;

   // Command from front end to back end
   typedef struct packed {
      logic [PAIR_BITS-1:0] key;
      logic                 tally;
      logic                 last;
   } cmd_type;

   // Result transaction
   typedef struct packed {
      logic [PAIR_BITS-1:0]      top_pair;
      logic [TOP_COUNT_BITS-1:0] top_count;
      logic                      pair_found;
      logic [DISTINCT_BITS-1:0]  distinct_pairs;
      logic                      table_full;
   } rsp_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MAX,
      ST_EMIT
   } state_type;

   function automatic logic is_blank(input logic [BYTE_BITS-1:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

endpackage

[rtl/byte_pair_frequency_max_top.sv]
// Channel   Ports                                   Handshake
// req       req_text_byte, req_end_of_text          push / full
// rsp       rsp_top_pair .. rsp_table_full          pop / empty
//
// A byte is taken every cycle while the two-entry command queue has room.
// A counted pair is looked up by comparing entries, one per cycle through the table
// RAM read port, then inserted or incremented; other non-final bytes cost none.
// The final byte adds a max scan over the used entries, then a step to load the result.
// Reset is synchronous; the table needs no clearing pass, only the entry count clears.
// A waiting result holds the back end at its load step; the queue then fills, raising full.
module byte_pair_frequency_max_top import bpfm_pkg::*; #(
   parameter int TABLE_DEPTH = 256,
   parameter int COUNT_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [BYTE_BITS-1:0]      req_text_byte,
   input  logic                      req_end_of_text,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [PAIR_BITS-1:0]      rsp_top_pair,
   output logic [TOP_COUNT_BITS-1:0] rsp_top_count,
   output logic                      rsp_pair_found,
   output logic [DISTINCT_BITS-1:0]  rsp_distinct_pairs,
   output logic                      rsp_table_full
);

   logic    q_push;
   cmd_type q_in;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_out;
   rsp_type rsp;

   // Front end: pair forming and classification
   bpfm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .q_full          (req_full),
      .q_push          (q_push),
      .q_cmd           (q_in)
   );

   // Decoupling queue
   bpfm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in),
      .full  (req_full),
      .pop   (q_pop),
      .valid (q_valid),
      .dout  (q_out)
   );

   // Back end: table lookup, update and max search
   bpfm_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_out),
      .cmd_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_top_pair       = rsp.top_pair;
   assign rsp_top_count      = rsp.top_count;
   assign rsp_pair_found     = rsp.pair_found;
   assign rsp_distinct_pairs = rsp.distinct_pairs;
   assign rsp_table_full     = rsp.table_full;

endmodule

[rtl/bpfm_ram.sv]
module bpfm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/bpfm_front.sv]
module bpfm_front import bpfm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [BYTE_BITS-1:0] req_text_byte,
   input  logic                 req_end_of_text,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_type              q_cmd
);

   logic                 prev_valid_ff, prev_valid_in;
   logic [BYTE_BITS-1:0] prev_byte_ff, prev_byte_in;
   logic                 accept;

   assign accept = req_push && !q_full;

   // Classify: a pair is counted only when both bytes are non-blank
   always_comb begin
      q_cmd.key   = {prev_byte_ff, req_text_byte};
      q_cmd.tally = prev_valid_ff && !is_blank(prev_byte_ff) && !is_blank(req_text_byte);
      q_cmd.last  = req_end_of_text;
      // bytes that neither count a pair nor end the text need no back-end work
      q_push      = accept && (q_cmd.tally || q_cmd.last);

      prev_byte_in  = prev_byte_ff;
      prev_valid_in = prev_valid_ff;
      if (accept) begin
         prev_byte_in  = req_text_byte;
         prev_valid_in = !req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         prev_byte_ff  <= '0;
      end else begin
         prev_valid_ff <= prev_valid_in;
         prev_byte_ff  <= prev_byte_in;
      end
   end

endmodule

[rtl/bpfm_queue.sv]
module bpfm_queue import bpfm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type dout
);

   // Two-entry command queue between front and back end
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full    = (fill_ff == 2'd2);
   assign valid   = (fill_ff != 2'd0);
   assign dout    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

[rtl/bpfm_back.sv]
module bpfm_back import bpfm_pkg::*; #(
   parameter int TABLE_DEPTH = 256,
   parameter int COUNT_BITS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp
);

   localparam int ENTRY_BITS = $clog2(TABLE_DEPTH);
   localparam int USED_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_BITS  = PAIR_BITS + COUNT_BITS;
   localparam int CNT_EXT    = (COUNT_BITS > TOP_COUNT_BITS) ? COUNT_BITS : TOP_COUNT_BITS;
   localparam int USED_EXT   = (USED_BITS > DISTINCT_BITS) ? USED_BITS : DISTINCT_BITS;

   localparam logic [COUNT_BITS-1:0]     CNT_ONE     = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0]     CNT_MAX     = {COUNT_BITS{1'b1}};
   localparam logic [CNT_EXT-1:0]        CNT_OUT_MAX = CNT_EXT'({TOP_COUNT_BITS{1'b1}});
   localparam logic [USED_EXT-1:0]       USED_OUT_MAX = USED_EXT'({DISTINCT_BITS{1'b1}});

   state_type             state_ff, state_in;
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic                  overflow_ff, overflow_in;
   logic [PAIR_BITS-1:0]  key_ff, key_in;
   logic                  last_ff, last_in;
   logic [USED_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic [ENTRY_BITS-1:0] cmp_idx_ff, cmp_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [PAIR_BITS-1:0]  best_pair_ff, best_pair_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic                  ram_we;
   logic [ENTRY_BITS-1:0] ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic [ENTRY_BITS-1:0] ram_raddr;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic [PAIR_BITS-1:0]  rd_pair;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic                  last_entry;
   logic                  room;
   logic                  issue;
   logic [CNT_EXT-1:0]    best_cnt_ext;
   logic [USED_EXT-1:0]   used_ext;
   logic                  found;

   // Pair/count table: {pair, count} per entry
   bpfm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_pair      = ram_rdata[WORD_BITS-1:COUNT_BITS];
   assign rd_cnt       = ram_rdata[COUNT_BITS-1:0];
   assign last_entry   = (USED_BITS'(cmp_idx_ff) == (used_ff - USED_BITS'(1)));
   assign room         = (used_ff < USED_BITS'(TABLE_DEPTH));
   assign issue        = (rd_idx_ff < used_ff);
   assign best_cnt_ext = CNT_EXT'(best_cnt_ff);
   assign used_ext     = USED_EXT'(used_ff);
   assign found        = (used_ff != '0);

   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

   // Sequencer: lookup scan, insert/increment, max scan, result load
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      overflow_in  = overflow_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      best_pair_in = best_pair_ff;
      best_cnt_in  = best_cnt_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = used_ff[ENTRY_BITS-1:0];
      ram_wdata    = {key_ff, CNT_ONE};
      ram_raddr    = rd_idx_ff[ENTRY_BITS-1:0];

      // result taken by the consumer
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               key_in  = cmd.key;
               last_in = cmd.last;
               rd_idx_in    = '0;
               cmp_valid_in = 1'b0;
               state_in     = cmd.last ? ST_MAX : ST_IDLE;
               if (cmd.tally) begin
                  if (!found) begin
                     // empty table: insert straight away
                     ram_we    = 1'b1;
                     ram_waddr = '0;
                     ram_wdata = {cmd.key, CNT_ONE};
                     used_in   = USED_BITS'(1);
                  end else begin
                     ram_raddr    = '0;
                     rd_idx_in    = USED_BITS'(1);
                     cmp_idx_in   = '0;
                     cmp_valid_in = 1'b1;
                     state_in     = ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            if (cmp_valid_ff && (rd_pair == key_ff)) begin
               // hit: saturating increment
               ram_we       = 1'b1;
               ram_waddr    = cmp_idx_ff;
               ram_wdata    = {key_ff, (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE};
               rd_idx_in    = '0;
               cmp_valid_in = 1'b0;
               state_in     = last_ff ? ST_MAX : ST_IDLE;
            end else if (cmp_valid_ff && last_entry) begin
               // miss on every entry: insert or flag overflow
               if (room) begin
                  ram_we  = 1'b1;
                  used_in = used_ff + USED_BITS'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               rd_idx_in    = '0;
               cmp_valid_in = 1'b0;
               state_in     = last_ff ? ST_MAX : ST_IDLE;
            end else begin
               cmp_valid_in = issue;
               cmp_idx_in   = rd_idx_ff[ENTRY_BITS-1:0];
               rd_idx_in    = issue ? rd_idx_ff + USED_BITS'(1) : rd_idx_ff;
            end
         end

         ST_MAX: begin
            if (!found) begin
               state_in = ST_EMIT;
            end else begin
               cmp_valid_in = issue;
               cmp_idx_in   = rd_idx_ff[ENTRY_BITS-1:0];
               rd_idx_in    = issue ? rd_idx_ff + USED_BITS'(1) : rd_idx_ff;
               if (cmp_valid_ff) begin
                  // strict compare keeps the earliest entry on ties
                  if ((cmp_idx_ff == '0) || (rd_cnt > best_cnt_ff)) begin
                     best_pair_in = rd_pair;
                     best_cnt_in  = rd_cnt;
                  end
                  if (last_entry) begin
                     cmp_valid_in = 1'b0;
                     state_in     = ST_EMIT;
                  end
               end
            end
         end

         ST_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in          = 1'b1;
               out_in.pair_found     = found;
               out_in.top_pair       = found ? best_pair_ff : '0;
               out_in.top_count      = !found ? '0 :
                                       (best_cnt_ext > CNT_OUT_MAX) ? {TOP_COUNT_BITS{1'b1}} :
                                       best_cnt_ext[TOP_COUNT_BITS-1:0];
               out_in.distinct_pairs = (used_ext > USED_OUT_MAX) ? {DISTINCT_BITS{1'b1}} :
                                       used_ext[DISTINCT_BITS-1:0];
               out_in.table_full     = overflow_ff;
               used_in               = '0;
               overflow_in           = 1'b0;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         overflow_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         overflow_ff  <= overflow_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      last_ff      <= last_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_pair_ff <= best_pair_in;
      best_cnt_ff  <= best_cnt_in;
      out_ff       <= out_in;
   end

endmodule

[rtl/bpfm_checker.sv]
`include "byte_pair_frequency_max_top_macros.svh"

module bpfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [7:0]  req_text_byte,
   input logic        req_end_of_text,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_top_pair,
   input logic [15:0] rsp_top_count,
   input logic        rsp_pair_found,
   input logic [8:0]  rsp_distinct_pairs,
   input logic        rsp_table_full
);

   // A waiting result holds until popped
   `BPFM_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_top_pair) && $stable(rsp_top_count) && $stable(rsp_distinct_pairs), "result changed while waiting")

   // Empty table reports all zero
   `BPFM_ASSERT_NOW(a_empty_zero, !rsp_empty && !rsp_pair_found, rsp_top_pair == 16'd0 && rsp_top_count == 16'd0 && rsp_distinct_pairs == 9'd0, "empty table result not zero")

   // A found pair has a nonzero count and at least one entry
   `BPFM_ASSERT_NOW(a_found_count, !rsp_empty && rsp_pair_found, rsp_top_count != 16'd0 && rsp_distinct_pairs != 9'd0, "found pair with zero count")

   // Overflow only happens with a populated table
   `BPFM_ASSERT_NOW(a_full_found, !rsp_empty && rsp_table_full, rsp_pair_found, "overflow without entries")

endmodule

bind byte_pair_frequency_max_top bpfm_checker u_bpfm_checker (.*);
